// ===== src/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Request and status codes, and the command and status groups that pass
// between the deque controller and its datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int VALUE_W = 32;
  localparam int ENTRY_W = 7;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_LIST_FWD   = 3'd4,
    REQ_LIST_BWD   = 3'd5,
    REQ_COUNT      = 3'd6
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef struct packed {
    logic    push_front;
    logic    push_back;
    logic    pop_front;
    logic    pop_back;
    logic    trav_start;
    logic    trav_back;
    logic    trav_next;
    logic    load_direct;
    status_t direct_status;
    logic    load_read;
    logic    read_trav;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic out_last;
  } dp_sts_t;

endpackage

// ===== src/deq_datapath.sv =====
// ----------------------------------------------------------------------------
// deq_datapath
// Ring store, front pointer, element count, traversal index and the result
// register of the deque.
// ----------------------------------------------------------------------------
module deq_datapath
  import deq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  logic [VALUE_W-1:0] push_value,
  output dp_sts_t            sts,
  output status_t            out_status,
  output logic [VALUE_W-1:0] out_value,
  output logic [ENTRY_W-1:0] out_count,
  output logic               out_last
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;

  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rdata;
  logic [IW-1:0]      front;
  logic [IW-1:0]      front_next;
  logic [IW-1:0]      front_inc;
  logic [IW-1:0]      front_dec;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [CW-1:0]      count_dec;
  logic [CW-1:0]      trav_idx;
  logic [CW-1:0]      trav_idx_next;
  logic               trav_back;
  logic               dir_back;
  logic [CW-1:0]      off;
  logic [SW-1:0]      sum;
  logic [IW-1:0]      slot;
  logic               rd_en;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;

  always_comb begin
    count_dec     = count - 1'b1;
    trav_idx_next = cmd.trav_start ? '0 : trav_idx + 1'b1;
    dir_back      = cmd.trav_start ? cmd.trav_back : trav_back;
    priority if (cmd.pop_front) begin
      off = '0;
    end else if (cmd.pop_back) begin
      off = count_dec;
    end else if (cmd.push_back) begin
      off = count;
    end else if (dir_back) begin
      off = count_dec - trav_idx_next;
    end else begin
      off = trav_idx_next;
    end
    sum  = SW'(front) + SW'(off);
    slot = (sum >= SW'(CAPACITY)) ? IW'(sum - SW'(CAPACITY)) : IW'(sum);

    front_inc = (front == IW'(CAPACITY - 1)) ? '0 : front + 1'b1;
    front_dec = (front == '0) ? IW'(CAPACITY - 1) : front - 1'b1;

    rd_en   = cmd.pop_front | cmd.pop_back | cmd.trav_start | cmd.trav_next;
    wr_en   = cmd.push_front | cmd.push_back;
    wr_addr = cmd.push_front ? front_dec : slot;

    priority if (cmd.push_front | cmd.push_back) begin
      count_next = count + 1'b1;
    end else if (cmd.pop_front | cmd.pop_back) begin
      count_next = count_dec;
    end else begin
      count_next = count;
    end

    priority if (cmd.push_front) begin
      front_next = front_dec;
    end else if (cmd.pop_front) begin
      front_next = front_inc;
    end else begin
      front_next = front;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= push_value;
    end
    if (rd_en) begin
      rdata <= mem[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front    <= '0;
      count    <= '0;
      out_last <= 1'b1;
    end else begin
      front <= front_next;
      count <= count_next;
      if (cmd.load_direct) begin
        out_last <= 1'b1;
      end else if (cmd.load_read) begin
        out_last <= cmd.read_trav ? (trav_idx == count_dec) : 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.trav_start | cmd.trav_next) begin
      trav_idx <= trav_idx_next;
      trav_back <= dir_back;
    end
    if (cmd.load_direct) begin
      out_status <= cmd.direct_status;
      out_value  <= '0;
      out_count  <= ENTRY_W'(count_next);
    end else if (cmd.load_read) begin
      out_status <= ST_OK;
      out_value  <= rdata;
      out_count  <= ENTRY_W'(count);
    end
  end

  assign sts.empty    = (count == '0);
  assign sts.full     = (count == CW'(CAPACITY));
  assign sts.out_last = out_last;

endmodule

// ===== src/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// Request decoder and sequencer: accepts requests, steps memory reads and
// traversals, and hands results to the output side.
// ----------------------------------------------------------------------------
module deq_ctrl
  import deq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  req_t    req,
  output logic    m_tvalid,
  input  logic    m_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_trav;
  logic   in_trav_next;
  logic   take;

  always_comb begin
    cmd          = '0;
    state_next   = state;
    in_trav_next = in_trav;
    s_tready     = (state == S_IDLE) || (state == S_OUT && m_tready && sts.out_last);
    take         = s_tvalid && s_tready;

    unique case (state)
      S_IDLE: begin
      end
      S_READ: begin
        cmd.load_read = 1'b1;
        cmd.read_trav = in_trav;
        state_next    = S_OUT;
      end
      S_OUT: begin
        if (m_tready) begin
          if (sts.out_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.trav_next = 1'b1;
            state_next    = S_READ;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (take) begin
      unique case (req)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          cmd.load_direct = 1'b1;
          if (sts.full) begin
            cmd.direct_status = ST_OVERFLOW;
          end else begin
            cmd.direct_status = ST_OK;
            cmd.push_front    = (req == REQ_PUSH_FRONT);
            cmd.push_back     = (req == REQ_PUSH_BACK);
          end
          state_next = S_OUT;
        end
        REQ_POP_FRONT, REQ_POP_BACK: begin
          if (sts.empty) begin
            cmd.load_direct   = 1'b1;
            cmd.direct_status = ST_UNDERFLOW;
            state_next        = S_OUT;
          end else begin
            cmd.pop_front = (req == REQ_POP_FRONT);
            cmd.pop_back  = (req == REQ_POP_BACK);
            in_trav_next  = 1'b0;
            state_next    = S_READ;
          end
        end
        REQ_LIST_FWD, REQ_LIST_BWD: begin
          if (sts.empty) begin
            cmd.load_direct   = 1'b1;
            cmd.direct_status = ST_UNDERFLOW;
            state_next        = S_OUT;
          end else begin
            cmd.trav_start = 1'b1;
            cmd.trav_back  = (req == REQ_LIST_BWD);
            in_trav_next   = 1'b1;
            state_next     = S_READ;
          end
        end
        REQ_COUNT: begin
          cmd.load_direct   = 1'b1;
          cmd.direct_status = ST_OK;
          state_next        = S_OUT;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      in_trav <= 1'b0;
    end else begin
      state   <= state_next;
      in_trav <= in_trav_next;
    end
  end

  assign m_tvalid = (state == S_OUT);

endmodule

// ===== src/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of 32-bit values in a ring store, with push, pop, list and
// count requests on a stream interface.
// ----------------------------------------------------------------------------
// Requests enter on s_* (tuser: request code, tdata: push value) and results
// leave on m_* (tuser: status, tdata: value and count, tlast: final result).
// Pushes and count requests show their result in the cycle after the transfer;
// pops pass through the registered read port of the ring store and then the
// result register. A traversal of N elements takes the same path, one store
// read per element, and reads each further element once the previous result
// was taken. A new request is taken in the same cycle that the final result
// of the previous one is taken. A push into a full deque answers with
// overflow; pops and lists of an empty deque answer once with underflow.
// Request code 7 is dropped without a result.
// ----------------------------------------------------------------------------
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] push_value
  input  logic [2:0]  s_tuser,   // [2:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] item_value, [38:32] entry_count, [39] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast    // last_flag
);

  dp_cmd_t            cmd;
  dp_sts_t            sts;
  status_t            out_status;
  logic [VALUE_W-1:0] out_value;
  logic [ENTRY_W-1:0] out_count;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .req      (req_t'(s_tuser)),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  deq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .push_value (s_tdata),
    .sts        (sts),
    .out_status (out_status),
    .out_value  (out_value),
    .out_count  (out_count),
    .out_last   (m_tlast)
  );

  assign m_tdata = {1'b0, out_count, out_value};
  assign m_tuser = out_status;

  a_overflow_full : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_OVERFLOW |-> m_tdata[38:32] == 7'(CAPACITY))
    else $error("overflow reported while deque not full");

  a_underflow_empty : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_UNDERFLOW |-> m_tdata[38:32] == 7'd0 && m_tlast)
    else $error("underflow result with nonzero count or not last");

  a_accept_on_last : assert property (@(posedge clk) disable iff (rst)
    s_tready && m_tvalid |-> m_tlast && m_tready)
    else $error("request taken while a traversal is still in progress");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[38:32] <= 7'(CAPACITY))
    else $error("entry count exceeds capacity");

endmodule

// ===== dv/double_ended_queue_test.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_test
// Self-checking bench for the ring-store deque. A shadow deque predicts every
// status, value, count and last marker. Directed requests cover the empty
// and full corners. Random traffic then mixes pushes, pops, lists and counts
// under random stalls on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module double_ended_queue_test;
  import deq_pkg::*;

  localparam int DEPTH = 64;
  localparam int LIMIT = 400000;
  localparam logic [2:0] REQ_UNUSED = 3'd7;

  typedef struct {
    status_t     status;
    logic [31:0] value;
    logic [6:0]  count;
    logic        last;
  } deq_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;  // [31:0] push_value
  logic [2:0]  s_tuser = '0;  // [2:0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;       // [31:0] item_value, [38:32] entry_count, [39] zero
  logic [1:0]  m_tuser;       // [1:0] status
  logic        m_tlast;

  logic [31:0] shadow_ring [DEPTH];
  logic [5:0]  shadow_front = '0;
  logic [6:0]  shadow_count = '0;
  deq_result_t pending_results [$];
  deq_result_t want_result;

  bit steady = 1'b0;
  int hold_off = 0;
  int cycle = 0;
  int errors = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int underflows_seen = 0;
  int overflows_seen = 0;
  int deepest_fill = 0;

  double_ended_queue #(.CAPACITY(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle++;
    if (cycle == LIMIT) begin
      $display("timeout after %0d cycles", cycle);
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void queue_result(status_t st, logic [31:0] v, logic last);
    deq_result_t r;
    r.status = st;
    r.value  = v;
    r.count  = shadow_count;
    r.last   = last;
    pending_results.push_back(r);
  endfunction

  function automatic void deque_apply(logic [2:0] code, logic [31:0] value);
    logic [5:0]  slot;
    logic [6:0]  off;
    logic [31:0] taken;
    case (code)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (shadow_count == DEPTH) begin
          queue_result(ST_OVERFLOW, '0, 1'b1);
        end else begin
          if (code == REQ_PUSH_FRONT) begin
            shadow_front = shadow_front - 6'd1;
            shadow_ring[shadow_front] = value;
          end else begin
            slot = shadow_front + shadow_count[5:0];
            shadow_ring[slot] = value;
          end
          shadow_count++;
          queue_result(ST_OK, '0, 1'b1);
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (shadow_count == 0) begin
          queue_result(ST_UNDERFLOW, '0, 1'b1);
        end else begin
          if (code == REQ_POP_FRONT) begin
            taken = shadow_ring[shadow_front];
            shadow_front = shadow_front + 6'd1;
          end else begin
            slot = shadow_front + shadow_count[5:0] - 6'd1;
            taken = shadow_ring[slot];
          end
          shadow_count--;
          queue_result(ST_OK, taken, 1'b1);
        end
      end
      REQ_LIST_FWD, REQ_LIST_BWD: begin
        if (shadow_count == 0) begin
          queue_result(ST_UNDERFLOW, '0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            off = (code == REQ_LIST_FWD) ? 7'(i) : 7'(int'(shadow_count) - 1 - i);
            slot = shadow_front + off[5:0];
            queue_result(ST_OK, shadow_ring[slot], i + 1 == shadow_count);
          end
        end
      end
      REQ_COUNT: begin
        queue_result(ST_OK, '0, 1'b1);
      end
      default: begin
      end
    endcase
    if (shadow_count > deepest_fill) deepest_fill = shadow_count;
  endfunction

  task automatic report_mismatch(string field, logic [39:0] got_val, logic [39:0] want_val);
    errors++;
    if (errors <= 50)
      $display("cycle %0d: %s mismatch, got %0h expected %0h", cycle, field, got_val,
               want_val);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, '0);
      end else begin
        want_result = pending_results.pop_front();
        if (want_result.status == ST_UNDERFLOW) underflows_seen++;
        if (want_result.status == ST_OVERFLOW) overflows_seen++;
        if (m_tuser !== want_result.status)
          report_mismatch("status", m_tuser, want_result.status);
        if (m_tdata[31:0] !== want_result.value)
          report_mismatch("item_value", m_tdata[31:0], want_result.value);
        if (m_tdata[38:32] !== want_result.count)
          report_mismatch("entry_count", m_tdata[38:32], want_result.count);
        if (m_tdata[39] !== 1'b0)
          report_mismatch("tdata pad", m_tdata[39], 1'b0);
        if (m_tlast !== want_result.last)
          report_mismatch("last_flag", m_tlast, want_result.last);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        m_tready <= 1'b0;
        hold_off--;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 20);
      end
    end
  end

  task automatic send_req(logic [2:0] code, logic [31:0] value);
    while (!steady && $urandom_range(99) < 20) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= code;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    deque_apply(code, value);
    requests_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(15))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random(int push_pct);
    logic [2:0] code;
    int roll;
    roll = $urandom_range(99);
    if (roll < push_pct) begin
      code = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    end else begin
      roll = $urandom_range(99);
      if (roll < 55) code = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
      else if (roll < 75) code = $urandom_range(1) ? REQ_LIST_BWD : REQ_LIST_FWD;
      else if (roll < 95) code = REQ_COUNT;
      else code = REQ_UNUSED;
    end
    send_req(code, pick_value());
  endtask

  function automatic int level_push_pct();
    if (shadow_count < 4) return 70;
    if (shadow_count > 40) return 25;
    return 48;
  endfunction

  task automatic test_empty_deque();
    send_req(REQ_POP_FRONT, 32'hFFFF_FFFF);
    send_req(REQ_POP_BACK, 32'h0);
    send_req(REQ_LIST_FWD, 32'h0);
    send_req(REQ_LIST_BWD, 32'hFFFF_FFFF);
    send_req(REQ_COUNT, 32'h5A5A_A5A5);
    send_req(REQ_UNUSED, 32'hA5A5_5A5A);
    wait_drained();
  endtask

  task automatic test_directed_ops();
    send_req(REQ_PUSH_FRONT, 32'h8000_0000);
    send_req(REQ_PUSH_BACK, 32'h7FFF_FFFF);
    send_req(REQ_PUSH_FRONT, 32'hFFFF_FFFF);
    send_req(REQ_PUSH_BACK, 32'h0000_0000);
    send_req(REQ_UNUSED, 32'h1234_5678);
    send_req(REQ_LIST_FWD, 32'h0);
    send_req(REQ_LIST_BWD, 32'h0);
    send_req(REQ_COUNT, 32'h0);
    send_req(REQ_POP_FRONT, 32'h0);
    send_req(REQ_POP_BACK, 32'h0);
    send_req(REQ_POP_BACK, 32'h0);
    send_req(REQ_POP_FRONT, 32'h0);
    send_req(REQ_POP_FRONT, 32'h0);
    send_req(REQ_LIST_FWD, 32'h0);
    wait_drained();
  endtask

  task automatic test_random_mix(int n);
    for (int i = 0; i < n; i++) send_random(level_push_pct());
    wait_drained();
  endtask

  task automatic test_fill_and_overflow();
    while (shadow_count < DEPTH)
      send_req($urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, pick_value());
    send_req(REQ_PUSH_FRONT, pick_value());
    send_req(REQ_PUSH_BACK, pick_value());
    send_req(REQ_PUSH_BACK, pick_value());
    send_req(REQ_LIST_FWD, 32'h0);
    send_req(REQ_LIST_BWD, 32'h0);
    send_req(REQ_COUNT, 32'h0);
    send_req(REQ_POP_FRONT, 32'h0);
    send_req(REQ_PUSH_BACK, pick_value());
    send_req(REQ_POP_BACK, 32'h0);
    send_req(REQ_PUSH_FRONT, pick_value());
    while (shadow_count > 0)
      send_req($urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT, 32'h0);
    send_req(REQ_POP_BACK, 32'h0);
    wait_drained();
  endtask

  task automatic test_output_holdoff();
    hold_off = 300;
    for (int i = 0; i < 12; i++) send_req(REQ_PUSH_BACK, pick_value());
    send_req(REQ_LIST_FWD, 32'h0);
    for (int i = 0; i < 7; i++) send_random(40);
    wait_drained();
  endtask

  task automatic test_steady_stream(int n);
    steady = 1'b1;
    for (int i = 0; i < n; i++) send_random(level_push_pct());
    wait_drained();
    steady = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_deque();
    test_directed_ops();
    test_random_mix(150);
    test_fill_and_overflow();
    test_output_holdoff();
    test_steady_stream(80);
    repeat (20) @(posedge clk);
    $display("%0d requests and %0d results checked: %0d underflow, %0d overflow",
             requests_sent, results_seen, underflows_seen, overflows_seen);
    $display("deepest fill %0d of %0d, %0d mismatches", deepest_fill, DEPTH, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/deq_pkg.sv
src/deq_datapath.sv
src/deq_ctrl.sv
src/double_ended_queue.sv
dv/double_ended_queue_test.sv
